// File: design/tkm_pkg.sv
// Package for the top-k logit mask unit: sizes, status and action codes,
// item structs and the controller/datapath link types. No dependencies.
package tkm_pkg;

  localparam int VOCAB_DEPTH = 8192;
  localparam int MAX_KEEP    = 64;
  localparam int LOGIT_W     = 16;

  localparam int ADDR_W = $clog2(VOCAB_DEPTH);
  localparam int CNT_W  = $clog2(VOCAB_DEPTH + 1);
  localparam int FILL_W = $clog2(MAX_KEEP + 1);
  localparam int SEL_W  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int KEEP_W = FILL_W;
  localparam int STS_W  = 2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [STS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STS_W-1:0] STS_OVERFLOW = 2'd1;
  localparam logic [STS_W-1:0] STS_BEYOND   = 2'd2;

  typedef struct packed {
    logic                      action;
    logic signed [LOGIT_W-1:0] logit_value;
    logic                      last_load;
    logic [ADDR_W-1:0]         read_position;
  } in_item_t;

  typedef struct packed {
    logic signed [LOGIT_W-1:0] result_value;
    logic                      is_masked;
    logic signed [LOGIT_W-1:0] kth_threshold;
    logic                      filter_active;
    logic [CNT_W-1:0]          vector_length;
    logic [STS_W-1:0]          status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic read;
    logic fix;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic drop;
  } dp_sts_t;

endpackage

// File: design/tkm_top_list.sv
// Sorted top list of the largest logits as a shifting insertion chain.
// Depends on tkm_pkg.
module tkm_top_list (
  input  logic                              clk_i,
  input  logic                              ins_en_i,
  input  logic signed [tkm_pkg::LOGIT_W-1:0] ins_value_i,
  input  logic [tkm_pkg::FILL_W-1:0]        fill_i,
  input  logic [tkm_pkg::SEL_W-1:0]         sel_i,
  output logic signed [tkm_pkg::LOGIT_W-1:0] sel_value_o
);
  import tkm_pkg::*;

  logic signed [LOGIT_W-1:0] cell_q [MAX_KEEP];
  logic signed [LOGIT_W-1:0] cell_d [MAX_KEEP];
  logic [MAX_KEEP-1:0]       keep_place;

  // A cell keeps its value if it is filled and not below the new one;
  // the first cell that does not keep takes the new value, the rest shift down.
  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      keep_place[i] = (FILL_W'(i) < fill_i) && (cell_q[i] >= ins_value_i);
    end
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (keep_place[i]) begin
        cell_d[i] = cell_q[i];
      end else if (i == 0) begin
        cell_d[i] = ins_value_i;
      end else if (keep_place[(i > 0) ? i - 1 : 0]) begin
        cell_d[i] = ins_value_i;
      end else begin
        cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_en_i) begin
      for (int i = 0; i < MAX_KEEP; i++) begin
        cell_q[i] <= cell_d[i];
      end
    end
  end

  assign sel_value_o = cell_q[sel_i];

endmodule

// File: design/tkm_ctrl.sv
// Controller for the top-k logit mask unit: sequences accept, threshold
// selection and result hand-off. Depends on tkm_pkg.
module tkm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               action_i,
  input  logic               last_load_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  tkm_pkg::dp_sts_t   sts_i,
  output tkm_pkg::ctrl_cmd_t cmd_o
);
  import tkm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FIX  = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_READ) begin
            cmd_o.read = 1'b1;
            state_d    = ST_RESP;
          end else begin
            cmd_o.load = 1'b1;
            if (last_load_i) begin
              state_d = ST_FIX;
            end else if (sts_i.drop) begin
              state_d = ST_RESP;
            end
          end
        end
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ACT_LOAD && last_load_i) |=> state_q == ST_FIX)
    else $error("last load did not go to threshold selection");

endmodule

// File: design/tkm_datapath.sv
// Datapath of the top-k logit mask unit: logit memory, counters, threshold,
// result register. Depends on tkm_pkg and tkm_top_list.
module tkm_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tkm_pkg::in_item_t         in_item_i,
  input  logic                      cfg_we_i,
  input  logic [tkm_pkg::KEEP_W-1:0] cfg_wdata_i,
  input  tkm_pkg::ctrl_cmd_t        cmd_i,
  output tkm_pkg::dp_sts_t          sts_o,
  output tkm_pkg::out_item_t        out_item_o
);
  import tkm_pkg::*;

  logic signed [LOGIT_W-1:0] mem [VOCAB_DEPTH];
  logic signed [LOGIT_W-1:0] rdata_q;

  logic [CNT_W-1:0]          cnt_q;
  logic [FILL_W-1:0]         fill_q;
  logic signed [LOGIT_W-1:0] thr_q;
  logic                      mask_q;
  logic                      complete_q;
  logic [KEEP_W-1:0]         keep_q;

  logic                      hold_rd_q;
  logic                      beyond_q;
  logic signed [LOGIT_W-1:0] hold_val_q;
  logic [STS_W-1:0]          hold_sts_q;
  out_item_t                 out_q;
  out_item_t                 res;

  logic [CNT_W-1:0]          eff_cnt;
  logic [FILL_W-1:0]         eff_fill;
  logic                      drop;
  logic                      beyond;
  logic [KEEP_W-1:0]         k_sat;
  logic                      mask_d;
  logic signed [LOGIT_W-1:0] sel_value;

  // a completed vector is dropped by the next load
  assign eff_cnt  = complete_q ? '0 : cnt_q;
  assign eff_fill = complete_q ? '0 : fill_q;
  assign drop     = (eff_cnt == CNT_W'(VOCAB_DEPTH));
  assign beyond   = (CNT_W'(in_item_i.read_position) >= cnt_q);
  assign sts_o.drop = drop;

  assign k_sat  = (keep_q > KEEP_W'(MAX_KEEP)) ? KEEP_W'(MAX_KEEP) : keep_q;
  assign mask_d = (k_sat != '0) && (CNT_W'(k_sat) < cnt_q) && (k_sat <= fill_q);

  tkm_top_list u_top_list (
    .clk_i       (clk_i),
    .ins_en_i    (cmd_i.load && !drop),
    .ins_value_i (in_item_i.logit_value),
    .fill_i      (eff_fill),
    .sel_i       (SEL_W'(k_sat - KEEP_W'(1))),
    .sel_value_o (sel_value)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !drop) begin
      mem[eff_cnt[ADDR_W-1:0]] <= in_item_i.logit_value;
    end
    if (cmd_i.read) begin
      rdata_q <= mem[in_item_i.read_position];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      fill_q     <= '0;
      thr_q      <= '0;
      mask_q     <= 1'b0;
      complete_q <= 1'b0;
      keep_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        if (complete_q) begin
          thr_q  <= '0;
          mask_q <= 1'b0;
        end
        complete_q <= in_item_i.last_load;
        if (drop) begin
          cnt_q  <= eff_cnt;
          fill_q <= eff_fill;
        end else begin
          cnt_q  <= eff_cnt + CNT_W'(1);
          fill_q <= eff_fill + FILL_W'(eff_fill < FILL_W'(MAX_KEEP));
        end
      end
      if (cmd_i.fix) begin
        mask_q <= mask_d;
        thr_q  <= mask_d ? sel_value : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hold_rd_q  <= 1'b0;
      beyond_q   <= 1'b0;
      hold_val_q <= drop ? '0 : in_item_i.logit_value;
      hold_sts_q <= drop ? STS_OVERFLOW : STS_OK;
    end
    if (cmd_i.read) begin
      hold_rd_q  <= 1'b1;
      beyond_q   <= beyond;
      hold_sts_q <= beyond ? STS_BEYOND : STS_OK;
    end
    if (cmd_i.publish) begin
      out_q <= res;
    end
  end

  always_comb begin
    res.result_value  = hold_rd_q ? (beyond_q ? '0 : rdata_q) : hold_val_q;
    res.is_masked     = hold_rd_q && !beyond_q && mask_q && (rdata_q < thr_q);
    res.kth_threshold = mask_q ? thr_q : '0;
    res.filter_active = mask_q;
    res.vector_length = cnt_q;
    res.status        = hold_sts_q;
  end

  assign out_item_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == ((cnt_q > CNT_W'(MAX_KEEP)) ? FILL_W'(MAX_KEEP) : FILL_W'(cnt_q)))
    else $error("top list fill out of step with logit count");

  assert property (@(posedge clk_i) disable iff (!rst_ni) mask_q |-> complete_q)
    else $error("masking on for an incomplete vector");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(VOCAB_DEPTH))
    else $error("logit count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |=> (!out_q.is_masked || out_q.filter_active))
    else $error("masked result while filter inactive");

endmodule

// File: design/top_k_logit_mask_unit.sv
// Top level of the top-k logit mask unit: joins tkm_ctrl and tkm_datapath.
// Depends on tkm_pkg.
//
// Works on one item at a time. A load that gives no result leaves it idle,
// so a plain logit stream loads at one value per clock through the
// insertion chain of the top list. A load marked last passes accept, a
// step that picks the k-th entry of the top list as threshold, then the
// result. A dropped load and a read pass accept, then the result step;
// a read takes its result from the logit memory's registered read port.
// A result waits in an output register; if that register is still full,
// the block holds in its result step until the item there is taken.
module top_k_logit_mask_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tkm_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tkm_pkg::out_item_t         out_item_o,
  input  logic                       cfg_we_i,
  input  logic [tkm_pkg::KEEP_W-1:0] cfg_wdata_i
);
  import tkm_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  tkm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (in_item_i.action),
    .last_load_i (in_item_i.last_load),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tkm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_item_o  (out_item_o)
  );

endmodule

// File: test/tb_top_k_logit_mask_unit.sv
// Self-checking testbench for top_k_logit_mask_unit: random and directed load/read items,
// with a top-k predictor in a small scoreboard class.
// Depends on tkm_pkg and the unit's RTL only.
module tb_top_k_logit_mask_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tkm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned CALM_ITEMS   = 300;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  // Mirrors the unit: logit store, descending top list, fixed threshold.
  class topk_board;
    logic signed [LOGIT_W-1:0] logits [VOCAB_DEPTH];
    logic signed [LOGIT_W-1:0] ranked [MAX_KEEP];
    logic signed [LOGIT_W-1:0] threshold;
    int unsigned count, ranked_fill, keep;
    bit complete, masking;
    out_item_t pending_results[$];
    int unsigned errors, checked, masked_seen, dropped, closed;

    function void set_keep(input int unsigned k);
      keep = k;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void predict_item(input in_item_t it);
      out_item_t r;
      int p;
      int unsigned k;
      bit emit;
      r = '0;
      if (it.action == ACT_LOAD) begin
        // first load after a closed vector starts a new one
        if (complete) begin
          count = 0;
          ranked_fill = 0;
          threshold = '0;
          masking = 1'b0;
          complete = 1'b0;
        end
        if (count >= VOCAB_DEPTH) begin
          r.status = STS_OVERFLOW;
          dropped++;
        end else begin
          logits[count] = it.logit_value;
          count++;
          p = 0;
          while (p < int'(ranked_fill) && ranked[p] >= it.logit_value) p++;
          if (p < MAX_KEEP) begin
            if (ranked_fill < MAX_KEEP) ranked_fill++;
            for (int i = int'(ranked_fill) - 1; i > p; i--) ranked[i] = ranked[i-1];
            ranked[p] = it.logit_value;
          end
          r.result_value = it.logit_value;
        end
        if (it.last_load) begin
          k = (keep > MAX_KEEP) ? MAX_KEEP : keep;
          masking = (k != 0) && (k < count) && (k <= ranked_fill);
          threshold = masking ? ranked[k-1] : '0;
          complete = 1'b1;
          closed++;
        end
        emit = it.last_load || (r.status != STS_OK);
      end else begin
        if (it.read_position >= count) begin
          r.status = STS_BEYOND;
        end else begin
          r.result_value = logits[it.read_position];
          r.is_masked = complete && masking && (r.result_value < threshold);
        end
        emit = 1'b1;
      end
      r.kth_threshold = (complete && masking) ? threshold : '0;
      r.filter_active = complete && masking;
      r.vector_length = CNT_W'(count);
      if (emit) pending_results.push_back(r);
    endfunction

    function void compare_field(input string name, input int want, input int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, actual %p", $time, got);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.is_masked) masked_seen++;
      compare_field("result_value", want.result_value, got.result_value);
      compare_field("is_masked", want.is_masked, got.is_masked);
      compare_field("kth_threshold", want.kth_threshold, got.kth_threshold);
      compare_field("filter_active", want.filter_active, got.filter_active);
      compare_field("vector_length", want.vector_length, got.vector_length);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_item_o;
  logic                cfg_we_i;
  logic [KEEP_W-1:0]   cfg_wdata_i;

  topk_board   board = new();
  int unsigned items_sent;
  int unsigned keep_writes;
  int unsigned cycles;
  bit          send_gaps;
  bit          recv_stalls;

  top_k_logit_mask_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_item_o);
  end

  // Result side: random stall bursts while enabled.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0 && recv_stalls && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 18);
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic in_item_t load_item(input logic signed [LOGIT_W-1:0] v, input bit last);
    in_item_t it;
    it.action = ACT_LOAD;
    it.logit_value = v;
    it.last_load = last;
    it.read_position = ADDR_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(input int unsigned pos);
    in_item_t it;
    it.action = ACT_READ;
    it.logit_value = LOGIT_W'($urandom);
    it.last_load = 1'($urandom);
    it.read_position = ADDR_W'(pos);
    return it;
  endfunction

  // Leaves valid high after the item is taken; release_input drops it.
  task automatic send_item(input in_item_t it);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.predict_item(it);
    items_sent++;
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    release_input();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_keep(input int unsigned k);
    drain_results();
    // let a silent load still in the chain settle
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= KEEP_W'(k);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_keep(k);
    keep_writes++;
  endtask

  task automatic run_vector(input int unsigned len, input int unsigned style, input bit close);
    logic signed [LOGIT_W-1:0] v;
    for (int unsigned n = 0; n < len; n++) begin
      case (style)
        0: v = LOGIT_W'($urandom);
        1: begin
          // few distinct values: ties around the threshold
          v = LOGIT_W'((int'($urandom_range(0, 4)) - 2) * 256);
        end
        default: v = $urandom_range(0, 1) ? LOGIT_W'(16'sh7fff - $urandom_range(0, 2))
                                          : LOGIT_W'(16'sh8000 + $urandom_range(0, 2));
      endcase
      if ($urandom_range(0, 9) == 0) send_item(read_item($urandom_range(0, n + 2)));
      send_item(load_item(v, close && (n == len - 1)));
    end
  endtask

  initial begin
    int unsigned random_base, len, pos;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty read, extremes and duplicates, late k change,
    // read before completion, saturated k
    send_item(read_item(0));
    write_keep(2);
    send_item(load_item(16'sh7fff, 1'b0));
    send_item(load_item(16'sh8000, 1'b0));
    send_item(load_item(16'sh0000, 1'b0));
    send_item(load_item(16'sh0100, 1'b0));
    send_item(load_item(16'sh0100, 1'b0));
    send_item(load_item(16'shffff, 1'b1));
    send_item(read_item(0));
    send_item(read_item(1));
    send_item(read_item(2));
    send_item(read_item(3));
    send_item(read_item(5));
    send_item(read_item(6));
    send_item(read_item(8191));
    write_keep(1);
    send_item(read_item(2));
    send_item(load_item(16'sh0005, 1'b0));
    send_item(read_item(0));
    send_item(read_item(1));
    send_item(load_item(16'sh0007, 1'b1));
    send_item(read_item(0));
    send_item(read_item(1));
    write_keep(127);
    send_item(load_item(16'sh0003, 1'b1));
    send_item(read_item(0));

    random_base = items_sent;
    while (items_sent < random_base + RANDOM_ITEMS) begin
      if (items_sent + CALM_ITEMS > random_base + RANDOM_ITEMS) begin
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
      end else begin
        send_gaps = $urandom_range(0, 2) != 0;
        recv_stalls = $urandom_range(0, 2) != 0;
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 7))
          0: write_keep(0);
          1: write_keep(1);
          2: write_keep(2);
          3: write_keep(63);
          4: write_keep(64);
          5: write_keep(65);
          6: write_keep(127);
          default: write_keep($urandom_range(0, 127));
        endcase
      end
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
      run_vector(len, $urandom_range(0, 2), $urandom_range(0, 9) != 0);
      repeat ($urandom_range(3, 20)) begin
        if ($urandom_range(0, 4) == 0) pos = $urandom_range(0, VOCAB_DEPTH - 1);
        else pos = $urandom_range(0, len);
        send_item(read_item(pos));
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d items with %0d k settings; %0d results checked, %0d vectors closed.",
             items_sent, keep_writes, board.checked, board.closed);
    $display("Saw %0d masked reads and %0d dropped loads past a full store.",
             board.masked_seen, board.dropped);
    if (board.pending() != 0)
      $display("%0t: %0d results never arrived", $time, board.pending());
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
